[hdl/rgb_to_yuv420_converter_assert.svh]
// Assertion macros for the RGB to YUV 4:2:0 converter.
// Taken by `include in the RTL files that carry assertions; needs clk_i and rst_ni in scope.
`ifndef RGB_TO_YUV420_CONVERTER_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define RY_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RY_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/rgb2yuv420_pkg.sv]
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// No dependencies; used by the scan, calc and top modules, not by the line store.
package rgb2yuv420_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 12;
  localparam int HGT_W     = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 13'd1024;

  // Q16 luma coefficients, summing to 65536.
  localparam logic [15:0] Y_R = 16'd19595;
  localparam logic [15:0] Y_G = 16'd38470;
  localparam logic [15:0] Y_B = 16'd7471;

  // Q16 chroma coefficients.
  localparam logic signed [17:0] U_R = -18'sd9642;
  localparam logic signed [17:0] U_G = -18'sd18931;
  localparam logic signed [17:0] U_B = 18'sd28574;
  localparam logic signed [17:0] V_R = 18'sd40305;
  localparam logic signed [17:0] V_G = -18'sd33750;
  localparam logic signed [17:0] V_B = -18'sd6554;

  // 510 in Q16.
  localparam logic signed [29:0] CHROMA_BIAS = 30'sd33423360;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Sums of a horizontal pixel pair, red in the top bits.
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
  } scan_info_t;

endpackage

[hdl/rgb2yuv420_line_mem.sv]
// Line store for the upper pixel-pair sums of each 2x2 block.
// One shared address, write and registered read; depends on nothing else.
module rgb2yuv420_line_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 27
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rgb2yuv420_scan.sv]
// Frame geometry registers and the column and row counters of the raster scan.
// Depends on rgb2yuv420_pkg.
module rgb2yuv420_scan #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned CW        = 12,
  parameter int unsigned AW        = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rgb2yuv420_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgb2yuv420_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                                  step_i,
  output rgb2yuv420_pkg::scan_info_t            info_o,
  output logic [AW-1:0]                         line_addr_o
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned WCMP_W =
      ((CW > rgb2yuv420_pkg::CFG_W) ? CW : rgb2yuv420_pkg::CFG_W) + 1;
  localparam logic [CW-1:0]     LINE_MASK = CW'(LINE_DEPTH - 1);
  localparam logic [WCMP_W-1:0] MAX_W     = WCMP_W'(MAX_WIDTH);
  localparam logic [WCMP_W-1:0] MIN_W     = WCMP_W'(2);
  localparam logic [rgb2yuv420_pkg::HGT_W-1:0] MAX_H =
      rgb2yuv420_pkg::HGT_W'(rgb2yuv420_pkg::MAX_HEIGHT);
  localparam logic [rgb2yuv420_pkg::HGT_W-1:0] MIN_H = rgb2yuv420_pkg::HGT_W'(2);

  logic [rgb2yuv420_pkg::CFG_W-1:0] width_q, width_d;
  logic [rgb2yuv420_pkg::CFG_W-1:0] height_q, height_d;
  logic [CW-1:0]                    col_q, col_d;
  logic [rgb2yuv420_pkg::ROW_W-1:0] row_q, row_d;

  logic [WCMP_W-1:0]                width_raw, width_eff, col_inc;
  logic [rgb2yuv420_pkg::HGT_W-1:0] height_eff, row_inc;
  logic [CW-1:0]                    col_half;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rgb2yuv420_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        rgb2yuv420_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Out-of-range geometry is clamped, so a wrap always happens.
  always_comb begin
    width_raw = WCMP_W'(width_q);
    if (width_raw < MIN_W) begin
      width_eff = MIN_W;
    end else if (width_raw > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = width_raw;
    end
    if (height_q < MIN_H) begin
      height_eff = MIN_H;
    end else if (height_q > MAX_H) begin
      height_eff = MAX_H;
    end else begin
      height_eff = height_q;
    end
  end

  always_comb begin
    col_inc = WCMP_W'(col_q) + WCMP_W'(1);
    row_inc = rgb2yuv420_pkg::HGT_W'(row_q) + rgb2yuv420_pkg::HGT_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (step_i) begin
      if (col_inc >= width_eff) begin
        col_d = '0;
        row_d = (row_inc >= height_eff) ? '0 : row_inc[rgb2yuv420_pkg::ROW_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgb2yuv420_pkg::DIM_RESET;
      height_q <= rgb2yuv420_pkg::DIM_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign col_half       = (col_q >> 1) & LINE_MASK;
  assign line_addr_o    = col_half[AW-1:0];
  assign info_o.odd_col = col_q[0];
  assign info_o.odd_row = row_q[0];

endmodule

[hdl/rgb2yuv420_calc.sv]
// Color arithmetic: luma of one pixel and chroma of a closed 2x2 block.
// Purely combinational; depends on rgb2yuv420_pkg.
module rgb2yuv420_calc (
  input  rgb2yuv420_pkg::pixel_t    pix_i,
  input  rgb2yuv420_pkg::pair_sum_t lower_i,
  input  rgb2yuv420_pkg::pair_sum_t upper_i,
  input  logic                      block_i,
  output logic [7:0]                luma_o,
  output logic [7:0]                blue_diff_o,
  output logic [7:0]                red_diff_o
);

  function automatic logic [7:0] chroma_byte(
    input logic signed [17:0] cr,
    input logic signed [17:0] cg,
    input logic signed [17:0] cb,
    input logic [9:0]         rs,
    input logic [9:0]         gs,
    input logic [9:0]         bs
  );
    logic signed [29:0] acc;
    logic [10:0]        q;
    acc = 30'(cr) * $signed({20'd0, rs})
        + 30'(cg) * $signed({20'd0, gs})
        + 30'(cb) * $signed({20'd0, bs})
        + rgb2yuv420_pkg::CHROMA_BIAS;
    q = acc[28:18];
    if (acc[29]) begin
      chroma_byte = 8'd0;
    end else if (q > 11'd255) begin
      chroma_byte = 8'd255;
    end else begin
      chroma_byte = q[7:0];
    end
  endfunction

  logic [23:0] y_acc;
  logic [9:0]  rs, gs, bs;

  assign y_acc = 24'(rgb2yuv420_pkg::Y_R) * 24'(pix_i.red)
               + 24'(rgb2yuv420_pkg::Y_G) * 24'(pix_i.green)
               + 24'(rgb2yuv420_pkg::Y_B) * 24'(pix_i.blue);
  assign luma_o = y_acc[23:16];

  assign rs = 10'(lower_i.red)   + 10'(upper_i.red);
  assign gs = 10'(lower_i.green) + 10'(upper_i.green);
  assign bs = 10'(lower_i.blue)  + 10'(upper_i.blue);

  assign blue_diff_o = block_i ? chroma_byte(rgb2yuv420_pkg::U_R, rgb2yuv420_pkg::U_G,
                                             rgb2yuv420_pkg::U_B, rs, gs, bs) : 8'd0;
  assign red_diff_o  = block_i ? chroma_byte(rgb2yuv420_pkg::V_R, rgb2yuv420_pkg::V_G,
                                             rgb2yuv420_pkg::V_B, rs, gs, bs) : 8'd0;

endmodule

[hdl/rgb_to_yuv420_converter.sv]
// Top level of the RGB to YUV 4:2:0 converter with BT.601 coefficients.
// Depends on rgb2yuv420_pkg, rgb2yuv420_scan, rgb2yuv420_line_mem, rgb2yuv420_calc.
//
// Usage: RGB pixels enter in raster order on the s_axis channel, one word per
// pixel. Every pixel leaves as one word on the m_axis channel carrying its luma.
// On the pixel at the odd column and odd row of each complete 2x2 block,
// m_axis_tuser_o is high and the word also carries the block's U and V bytes;
// otherwise those bytes are zero. Frame width and height are set through the
// write port (index 0 width, index 1 height) while the block is idle.
// Each pixel passes the input register and then the result register. Throughput
// is one pixel per cycle while the receiver keeps up: the input register, the
// line-store read and the result register each take one pixel per clock, so a
// new pixel may enter every cycle. When the receiver stalls, the result register
// and then the input stage fill and s_axis_tready_o drops; nothing is lost. Reset
// clears the counters and the stored left pixel and sets both dimensions to 1024.
// The line store is not cleared and needs no clearing pass: each entry is written
// on an even row before the next odd row reads it.
module rgb_to_yuv420_converter #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [23:0]                           s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // luma [7:0], blue_diff [15:8], red_diff [23:16]
  output logic [23:0]                           m_axis_tdata_o,
  // chroma_valid [0]
  output logic                                  m_axis_tuser_o,
  input  logic                                  cfg_we_i,
  input  logic [rgb2yuv420_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgb2yuv420_pkg::CFG_W-1:0]      cfg_data_i
);

  `include "rgb_to_yuv420_converter_assert.svh"

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int unsigned PW = $bits(rgb2yuv420_pkg::pair_sum_t);

  logic                       accept, advance;
  rgb2yuv420_pkg::scan_info_t info;
  logic [AW-1:0]              line_addr;
  logic                       line_we, line_re;
  rgb2yuv420_pkg::pixel_t     pix_in, left_q, left_d;
  rgb2yuv420_pkg::pair_sum_t  pair_sum, upper_rd;
  logic [PW-1:0]              line_rdata;

  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_block_q;
  rgb2yuv420_pkg::pixel_t     s1_pix_q;
  rgb2yuv420_pkg::pair_sum_t  s1_pair_q;

  logic                       out_valid_q, out_valid_d;
  logic                       out_chroma_q;
  logic [23:0]                out_data_q;
  logic [7:0]                 luma, blue_diff, red_diff;

  assign s_axis_tready_o = !s1_valid_q || !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);

  assign pix_in = rgb2yuv420_pkg::pixel_t'(s_axis_tdata_i);

  rgb2yuv420_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .info_o      (info),
    .line_addr_o (line_addr)
  );

  // The pair sum is formed on entry, so the even row can store it at once.
  assign pair_sum.red   = 9'(pix_in.red)   + 9'(left_q.red);
  assign pair_sum.green = 9'(pix_in.green) + 9'(left_q.green);
  assign pair_sum.blue  = 9'(pix_in.blue)  + 9'(left_q.blue);

  assign line_we = accept && info.odd_col && !info.odd_row;
  assign line_re = accept && info.odd_col && info.odd_row;

  rgb2yuv420_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (PW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .re_i    (line_re),
    .addr_i  (line_addr),
    .wdata_i (pair_sum),
    .rdata_o (line_rdata)
  );

  assign upper_rd = rgb2yuv420_pkg::pair_sum_t'(line_rdata);

  assign left_d      = accept ? pix_in : left_q;
  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pix_in;
      s1_pair_q  <= pair_sum;
      s1_block_q <= info.odd_col && info.odd_row;
    end
  end

  rgb2yuv420_calc u_calc (
    .pix_i       (s1_pix_q),
    .lower_i     (s1_pair_q),
    .upper_i     (upper_rd),
    .block_i     (s1_block_q),
    .luma_o      (luma),
    .blue_diff_o (blue_diff),
    .red_diff_o  (red_diff)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q   <= {red_diff, blue_diff, luma};
      out_chroma_q <= s1_block_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_chroma_q;

  `RY_ASSERT(a_line_no_rw_collision, !(line_we && line_re),
             "line store written and read in the same cycle")
  `RY_ASSERT(a_stall_blocks_input,
             (s1_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o,
             "input accepted while both stages are full and stalled")
  `RY_ASSERT(a_chroma_zero_without_flag,
             (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[23:8] == 16'd0),
             "chroma bytes nonzero on a word without chroma")
  `RY_ASSERT_ALWAYS(a_reset_clears_output, !rst_ni |=> (!m_axis_tvalid_o && !s1_valid_q),
                    "pipeline holds data during reset")

endmodule

[tb/sv/yuv420_result_checker.sv]
// Result checker for the RGB to YUV 4:2:0 converter: follows the register writes,
// predicts one YUV word per accepted pixel and compares every output word.
// Depends on rgb2yuv420_pkg for the pixel type and the register indexes.
module yuv420_result_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  pix_valid_i,
  input  logic                                  pix_ready_i,
  input  rgb2yuv420_pkg::pixel_t                pix_data_i,
  input  logic                                  yuv_valid_i,
  input  logic                                  yuv_ready_i,
  // luma [7:0], blue_diff [15:8], red_diff [23:16]
  input  logic [23:0]                           yuv_data_i,
  // chroma_valid [0]
  input  logic                                  yuv_chroma_i,
  input  logic                                  cfg_we_i,
  input  logic [rgb2yuv420_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgb2yuv420_pkg::CFG_W-1:0]      cfg_data_i,
  output int                                    mismatch_count_o,
  output int                                    words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DEPTH = 2048;
  localparam int unsigned DIM_MAX    = 4096;

  // BT.601 weights in Q16.
  localparam longint LUMA_R = 19595;
  localparam longint LUMA_G = 38470;
  localparam longint LUMA_B = 7471;
  localparam longint CB_R   = -9642;
  localparam longint CB_G   = -18931;
  localparam longint CB_B   = 28574;
  localparam longint CR_R   = 40305;
  localparam longint CR_G   = -33750;
  localparam longint CR_B   = -6554;
  localparam longint OFFSET = 510 * 65536;

  typedef struct packed {
    logic       chroma;
    logic [7:0] red_diff;
    logic [7:0] blue_diff;
    logic [7:0] luma;
  } yuv_word_t;

  yuv_word_t expected_yuv [$];

  // Pair sums of the even row, one entry per column pair.
  logic [8:0] upper_red   [LINE_DEPTH];
  logic [8:0] upper_green [LINE_DEPTH];
  logic [8:0] upper_blue  [LINE_DEPTH];

  rgb2yuv420_pkg::pixel_t             left_px    = '0;
  int unsigned                        col_pos    = 0;
  int unsigned                        row_pos    = 0;
  logic [rgb2yuv420_pkg::CFG_W-1:0]   width_reg  = 13'd1024;
  logic [rgb2yuv420_pkg::CFG_W-1:0]   height_reg = 13'd1024;
  int                                 error_total = 0;

  function automatic int unsigned span(logic [rgb2yuv420_pkg::CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic logic [7:0] chroma_byte(longint cr, longint cg, longint cb,
                                             longint rs, longint gs, longint bs);
    longint acc;
    acc = cr * rs + cg * gs + cb * bs + OFFSET;
    if (acc < 0) return 8'd0;
    acc = acc >>> 18;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  // Works out the word for one pixel and moves the scan position on.
  function automatic yuv_word_t predict_yuv(rgb2yuv420_pkg::pixel_t px);
    yuv_word_t   res;
    int unsigned w, h, slot;
    longint      pr, pg, pb, luma_acc;
    res = '0;
    w = span(width_reg);
    h = span(height_reg);
    luma_acc = LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue;
    res.luma = luma_acc[23:16];
    if (col_pos[0]) begin
      pr = px.red + left_px.red;
      pg = px.green + left_px.green;
      pb = px.blue + left_px.blue;
      slot = (col_pos >> 1) % LINE_DEPTH;
      if (!row_pos[0]) begin
        upper_red[slot]   = pr[8:0];
        upper_green[slot] = pg[8:0];
        upper_blue[slot]  = pb[8:0];
      end else begin
        pr = pr + upper_red[slot];
        pg = pg + upper_green[slot];
        pb = pb + upper_blue[slot];
        res.chroma    = 1'b1;
        res.blue_diff = chroma_byte(CB_R, CB_G, CB_B, pr, pg, pb);
        res.red_diff  = chroma_byte(CR_R, CR_G, CR_B, pr, pg, pb);
      end
    end
    left_px = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  function automatic void compare_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    yuv_word_t seen, want;
    if (!rst_ni) begin
      expected_yuv.delete();
      left_px    = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = 13'd1024;
      height_reg = 13'd1024;
      mismatch_count_o <= 0;
      words_pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rgb2yuv420_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data_i;
        end else if (cfg_idx_i == rgb2yuv420_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_data_i;
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        expected_yuv.push_back(predict_yuv(pix_data_i));
      end
      if (yuv_valid_i && yuv_ready_i) begin
        seen = {yuv_chroma_i, yuv_data_i};
        if (expected_yuv.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, got %h", $time, seen);
          error_total++;
        end else begin
          want = expected_yuv.pop_front();
          compare_field("luma", want.luma, seen.luma);
          compare_field("chroma_valid", want.chroma, seen.chroma);
          compare_field("blue_diff", want.blue_diff, seen.blue_diff);
          compare_field("red_diff", want.red_diff, seen.red_diff);
        end
      end
      mismatch_count_o <= error_total;
      words_pending_o  <= expected_yuv.size();
    end
  end

endmodule

[tb/sv/rgb_to_yuv420_converter_test.sv]
// Testbench top for the RGB to YUV 4:2:0 converter: drives pixels, frame sizes
// and output stalls, and gives the verdict. Depends on rgb2yuv420_pkg, the
// converter RTL and yuv420_result_checker.
module rgb_to_yuv420_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                 clk_i           = 1'b0;
  logic                                 rst_ni          = 1'b0;
  logic                                 s_axis_tvalid_i = 1'b0;
  logic                                 s_axis_tready_o;
  rgb2yuv420_pkg::pixel_t               s_axis_tdata_i  = '0;
  logic                                 m_axis_tvalid_o;
  logic                                 m_axis_tready_i = 1'b0;
  logic [23:0]                          m_axis_tdata_o;
  logic                                 m_axis_tuser_o;
  logic                                 cfg_we_i        = 1'b0;
  logic [rgb2yuv420_pkg::CFG_IDX_W-1:0] cfg_idx_i       = rgb2yuv420_pkg::REG_FRAME_WIDTH;
  logic [rgb2yuv420_pkg::CFG_W-1:0]     cfg_data_i      = '0;

  int mismatch_count;
  int words_pending;
  int sender_idle_pct   = 34;
  int receiver_idle_pct = 87;
  int random_sent       = 0;

  // Packed as blue, green, red from the top byte down.
  rgb2yuv420_pkg::pixel_t corner_px [9] = '{24'h000000, 24'hFFFFFF, 24'h0000FF,
                                            24'h00FF00, 24'hFF0000, 24'h808080,
                                            24'h00FFFF, 24'hFFFF00, 24'hFF00FF};
  rgb2yuv420_pkg::pixel_t solid_px  [4] = '{24'hFFFFFF, 24'h000000, 24'h0000FF,
                                            24'h00FF00};

  rgb_to_yuv420_converter i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  yuv420_result_checker i_checker (
    .clk_i,
    .rst_ni,
    .pix_valid_i      (s_axis_tvalid_i),
    .pix_ready_i      (s_axis_tready_o),
    .pix_data_i       (s_axis_tdata_i),
    .yuv_valid_i      (m_axis_tvalid_o),
    .yuv_ready_i      (m_axis_tready_i),
    .yuv_data_i       (m_axis_tdata_o),
    .yuv_chroma_i     (m_axis_tuser_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic int unsigned dim_of(int unsigned v);
    if (v < 2) return 2;
    if (v > 4096) return 4096;
    return v;
  endfunction

  // Mostly random levels, with the rails showing up often.
  function automatic logic [7:0] shade();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb2yuv420_pkg::pixel_t random_pixel();
    rgb2yuv420_pkg::pixel_t px;
    px.red   = shade();
    px.green = shade();
    px.blue  = shade();
    return px;
  endfunction

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    sender_idle_pct   <= sender_pct;
    receiver_idle_pct <= receiver_pct;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rgb2yuv420_pkg::REG_FRAME_WIDTH;
    cfg_data_i <= rgb2yuv420_pkg::CFG_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= rgb2yuv420_pkg::REG_FRAME_HEIGHT;
    cfg_data_i <= rgb2yuv420_pkg::CFG_W'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic send_pixel(input rgb2yuv420_pkg::pixel_t px);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // Every phase but the clamped one ends on a frame boundary, so the scan
  // restarts at the top left; no odd row reads a line entry not written first.
  task automatic drain();
    pause_until_drained();
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_frames(input int unsigned w, input int unsigned h,
                             input int unsigned frames);
    set_frame(w, h);
    repeat (frames * dim_of(w) * dim_of(h)) begin
      if (random_sent == 500 || $urandom_range(149) == 0) pause_until_drained();
      send_pixel(random_pixel());
      random_sent++;
    end
    drain();
  endtask

  initial begin
    int unsigned w, h, frames;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A 3x3 frame has a trailing odd column and a trailing odd row.
    set_frame(3, 3);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    // Both registers below range clamp to 2x2; the solid red and green frames
    // drive V to its rails.
    set_frame(0, 1);
    foreach (solid_px[i]) repeat (4) send_pixel(solid_px[i]);
    drain();

    while (random_sent < 1100) begin
      if (random_sent < 367) begin
        set_idle(34, 87);
      end else if (random_sent < 733) begin
        set_idle(87, 34);
      end else begin
        set_idle(0, 0);
      end
      case ($urandom_range(9))
        0: w = $urandom_range(1, 0);
        1: w = $urandom_range(64, 25);
        default: w = $urandom_range(24, 2);
      endcase
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 0) : $urandom_range(9, 2);
      frames = $urandom_range(3, 1);
      send_frames(w, h, frames);
    end

    // Registers above range clamp, so twenty pixels stay on the first row. A
    // narrower width written then wraps the column at the next pixel, and the
    // following row closes blocks on the pairs just stored.
    set_frame(13'h1FFF, 13'h1FFF);
    repeat (20) send_pixel(random_pixel());
    drain();
    set_frame(20, 2);
    repeat (21) send_pixel(random_pixel());
    drain();

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS rgb_to_yuv420_converter");
    end else begin
      $display("FAIL rgb_to_yuv420_converter");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL rgb_to_yuv420_converter");
    $finish;
  end

endmodule
